// ===== hdl/kwm_pkg.sv =====
// Package for the k-way sorted run merge unit.
// Holds the sizing constants and the control structs shared by the store,
// the scan unit and the top level. Depends on nothing.
package kwm_pkg;

    localparam int MAX_WAYS   = 8;
    localparam int DATA_WIDTH = 32;
    localparam int WAY_W      = $clog2(MAX_WAYS);
    localparam int CNT_W      = $clog2(MAX_WAYS + 1);
    localparam int CFG_W      = 4;
    localparam int IN_WAY_W   = 3;
    localparam logic [CFG_W-1:0] ACTIVE_WAYS_RESET = CFG_W'(2);

    typedef logic [MAX_WAYS-1:0]   way_vec_t;
    typedef logic [WAY_W-1:0]      way_idx_t;
    typedef logic [DATA_WIDTH-1:0] data_t;

    typedef struct packed {
        logic     wr_en;
        way_idx_t wr_way;
        data_t    wr_value;
        logic     wr_last;
        logic     pop_en;
        way_idx_t pop_way;
        logic     clear_all;
    } store_cmd_t;

    typedef struct packed {
        logic     clear;
        logic     load;
        way_idx_t way;
        data_t    value;
    } scan_ctl_t;

endpackage

// ===== hdl/kwm_head_store.sv =====
// Head store of the merge unit: one head value per way, with valid, last
// and retired flags. Uses the command struct and sizes from kwm_pkg.
module kwm_head_store
    import kwm_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  store_cmd_t cmd,
    input  way_idx_t   rd_way,
    output data_t      rd_value,
    output way_vec_t   valid_vec,
    output way_vec_t   last_vec,
    output way_vec_t   retired_vec
);

    data_t    head_value_reg [MAX_WAYS];
    way_vec_t valid_reg, valid_next;
    way_vec_t last_reg, last_next;
    way_vec_t retired_reg, retired_next;

    always_comb begin
        valid_next   = valid_reg;
        last_next    = last_reg;
        retired_next = retired_reg;
        if (cmd.clear_all) begin
            valid_next   = '0;
            last_next    = '0;
            retired_next = '0;
        end else begin
            if (cmd.pop_en) begin
                valid_next[cmd.pop_way] = 1'b0;
                if (last_reg[cmd.pop_way]) begin
                    retired_next[cmd.pop_way] = 1'b1;
                    last_next[cmd.pop_way]    = 1'b0;
                end
            end
            if (cmd.wr_en) begin
                valid_next[cmd.wr_way] = 1'b1;
                last_next[cmd.wr_way]  = cmd.wr_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            last_reg    <= '0;
            retired_reg <= '0;
        end else begin
            valid_reg   <= valid_next;
            last_reg    <= last_next;
            retired_reg <= retired_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en && !cmd.clear_all) begin
            head_value_reg[cmd.wr_way] <= cmd.wr_value;
        end
    end

    assign rd_value    = head_value_reg[rd_way];
    assign valid_vec   = valid_reg;
    assign last_vec    = last_reg;
    assign retired_vec = retired_reg;

endmodule

// ===== hdl/kwm_min_scan.sv =====
// Shared signed comparator of the merge unit, fed one head per cycle.
// Keeps the running minimum and its way; the lowest way wins ties.
// Uses the control struct and sizes from kwm_pkg.
module kwm_min_scan
    import kwm_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  scan_ctl_t ctl,
    output logic      found,
    output way_idx_t  best_way,
    output data_t     best_value
);

    logic     found_reg;
    way_idx_t best_way_reg;
    data_t    best_value_reg;
    logic     take;

    assign take = ctl.load &&
                  (!found_reg || ($signed(ctl.value) < $signed(best_value_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (ctl.clear) begin
            found_reg <= 1'b0;
        end else if (take) begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!ctl.clear && take) begin
            best_way_reg   <= ctl.way;
            best_value_reg <= ctl.value;
        end
    end

    assign found      = found_reg;
    assign best_way   = best_way_reg;
    assign best_value = best_value_reg;

endmodule

// ===== hdl/k_way_sorted_run_merge_unit.sv =====
// K-way sorted run merge unit: top level with the sequencer and output register.
// An accepted item is written to the head store, then a scan over the active ways runs
// through the shared comparator, then a decision step and the result item; burst members
// after a retiring emit repeat the scan.
// Reset is synchronous and active low; it clears the head and scan flags and sets active ways to two.
// Depends on kwm_pkg, kwm_head_store and kwm_min_scan.
module k_way_sorted_run_merge_unit
    import kwm_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [CFG_W-1:0]            cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [IN_WAY_W-1:0]         s_way_index,
    input  logic signed [DATA_WIDTH-1:0] s_element_value,
    input  logic                        s_last_in_run,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [DATA_WIDTH-1:0] m_merged_value,
    output logic [IN_WAY_W-1:0]         m_source_way,
    output logic                        m_refill_wanted,
    output logic                        m_merge_done,
    output logic                        m_burst_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CFG_W-1:0] active_ways_reg;
    way_idx_t         idx_reg, idx_next;

    data_t            out_value_reg;
    way_idx_t         out_way_reg;
    logic             out_refill_reg, out_done_reg;

    store_cmd_t       cmd;
    scan_ctl_t        sctl;
    data_t            rd_value;
    way_vec_t         valid_vec, last_vec, retired_vec;
    logic             found;
    way_idx_t         best_way;
    data_t            best_value;

    logic [CNT_W-1:0] way_cnt;
    way_vec_t         active_mask;
    way_vec_t         retired_after;
    logic             done_now;
    logic             in_acc, in_take, out_acc, scan_end;
    way_idx_t         in_way;

    always_comb begin
        if (active_ways_reg == '0) begin
            way_cnt = CNT_W'(1);
        end else if (CNT_W'(active_ways_reg) > CNT_W'(MAX_WAYS)) begin
            way_cnt = CNT_W'(MAX_WAYS);
        end else begin
            way_cnt = CNT_W'(active_ways_reg);
        end
        for (int i = 0; i < MAX_WAYS; i++) begin
            active_mask[i] = CNT_W'(i) < way_cnt;
        end
    end

    assign in_way   = WAY_W'(s_way_index);
    assign s_ready  = (state_reg == ST_IDLE);
    assign in_acc   = s_valid && s_ready;
    assign in_take  = in_acc && (CNT_W'(s_way_index) < way_cnt) &&
                      !retired_vec[in_way] && !valid_vec[in_way];
    assign out_acc  = m_valid && m_ready;
    assign scan_end = (CNT_W'(idx_reg) == way_cnt - CNT_W'(1));

    always_comb begin
        retired_after = retired_vec;
        if (last_vec[best_way]) begin
            retired_after[best_way] = 1'b1;
        end
        done_now = &(retired_after | ~active_mask);
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        sctl       = '0;
        sctl.way   = idx_reg;
        sctl.value = rd_value;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    state_next = ST_SCAN;
                    idx_next   = '0;
                    sctl.clear = 1'b1;
                end
            end
            ST_SCAN: begin
                if (!retired_vec[idx_reg] && !valid_vec[idx_reg]) begin
                    state_next = ST_IDLE;
                end else begin
                    sctl.load = !retired_vec[idx_reg];
                    if (scan_end) begin
                        state_next = ST_PICK;
                    end else begin
                        idx_next = idx_reg + WAY_W'(1);
                    end
                end
            end
            ST_PICK: begin
                state_next = found ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_acc) begin
                    if (out_refill_reg || out_done_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                        sctl.clear = 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd           = '0;
        cmd.wr_en     = in_take;
        cmd.wr_way    = in_way;
        cmd.wr_value  = s_element_value;
        cmd.wr_last   = s_last_in_run;
        cmd.pop_en    = out_acc;
        cmd.pop_way   = out_way_reg;
        cmd.clear_all = out_acc && out_done_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            idx_reg         <= '0;
            active_ways_reg <= ACTIVE_WAYS_RESET;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_wr_en) begin
                active_ways_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PICK) begin
            out_value_reg  <= best_value;
            out_way_reg    <= best_way;
            out_refill_reg <= !last_vec[best_way];
            out_done_reg   <= done_now;
        end
    end

    kwm_head_store u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .rd_way      (idx_reg),
        .rd_value    (rd_value),
        .valid_vec   (valid_vec),
        .last_vec    (last_vec),
        .retired_vec (retired_vec)
    );

    kwm_min_scan u_scan (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (sctl),
        .found      (found),
        .best_way   (best_way),
        .best_value (best_value)
    );

    assign m_valid         = (state_reg == ST_EMIT);
    assign m_merged_value  = out_value_reg;
    assign m_source_way    = IN_WAY_W'(out_way_reg);
    assign m_refill_wanted = out_refill_reg;
    assign m_merge_done    = out_done_reg;
    assign m_burst_last    = out_refill_reg || out_done_reg;

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken while a result item is pending");

    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_merge_done) |=> (retired_vec == '0 && valid_vec == '0))
        else $error("state not cleared after the final retire");

    a_emit_valid_head: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> valid_vec[out_way_reg])
        else $error("result item taken from a way without a head");

    a_refill_unretired: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_refill_wanted) |=> !retired_vec[$past(out_way_reg)])
        else $error("way retired although a refill was asked for");

endmodule
